// ===== hw/rtl/blt_pkg.sv =====
package blt_pkg;

    // Record kinds on the output channel
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } rec_kind_t;

    // Token classes
    typedef enum logic [2:0] {
        CLS_KANJI  = 3'd0,
        CLS_WORD   = 3'd1,
        CLS_NUMBER = 3'd2,
        CLS_STRING = 3'd3,
        CLS_SYMBOL = 3'd4
    } tok_class_t;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_KTRAIL = 3'd1,
        MODE_KOPEN  = 3'd2,
        MODE_WORD   = 3'd3,
        MODE_NUMBER = 3'd4,
        MODE_STRING = 3'd5,
        MODE_ESCAPE = 3'd6
    } scan_mode_t;

    // Kanji encoding register values
    localparam logic ENC_SJIS = 1'b0;
    localparam logic ENC_EUC  = 1'b1;

    // Shift-JIS lead and trail ranges
    localparam logic [7:0] SJIS_LEAD_A_LO  = 8'h81;
    localparam logic [7:0] SJIS_LEAD_A_HI  = 8'h9F;
    localparam logic [7:0] SJIS_LEAD_B_LO  = 8'hE0;
    localparam logic [7:0] SJIS_LEAD_B_HI  = 8'hFC;
    localparam logic [7:0] SJIS_TRAIL_A_LO = 8'h40;
    localparam logic [7:0] SJIS_TRAIL_A_HI = 8'h7E;
    localparam logic [7:0] SJIS_TRAIL_B_LO = 8'h80;
    localparam logic [7:0] SJIS_TRAIL_B_HI = 8'hFC;

    // EUC range, lead and trail alike
    localparam logic [7:0] EUC_LO = 8'hA1;
    localparam logic [7:0] EUC_HI = 8'hFE;

    // Characters with a meaning of their own
    localparam logic [7:0] CHR_NUL       = 8'h00;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHR_DOT       = 8'h2E;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_UPPER_E   = 8'h45;
    localparam logic [7:0] CHR_LOWER_E   = 8'h65;

    // Records caused by one item at most
    localparam int unsigned MAX_RECS = 3;

    typedef struct packed {
        rec_kind_t  kind;
        logic [7:0] data;
        tok_class_t cls;
        logic       start;
    } record_t;

    // All records of one item, first in slot 0
    typedef struct packed {
        record_t [MAX_RECS-1:0] rec;
        logic [1:0]             cnt;
    } bundle_t;

    typedef struct packed {
        logic    vld;
        bundle_t bundle;
    } push_t;

    // Class of the token open in a mode
    function automatic tok_class_t mode_class(input scan_mode_t m);
        tok_class_t c;
        unique case (m)
            MODE_WORD:   c = CLS_WORD;
            MODE_NUMBER: c = CLS_NUMBER;
            MODE_STRING,
            MODE_ESCAPE: c = CLS_STRING;
            default:     c = CLS_KANJI;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/blt_scan.sv =====
module blt_scan (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     in_byte,
    input  logic           line_end,
    input  logic           kanji_enc,
    input  logic           q_full,
    output blt_pkg::push_t push
);
    import blt_pkg::*;

    localparam int unsigned NUM_CAND = 6;

    logic       in_vld_reg, in_vld_next;
    logic [7:0] byte_reg;
    logic       eol_reg;
    logic       accept;
    logic       go;

    scan_mode_t mode_reg, mode_next, mode_step, beg_mode;
    logic [7:0] quote_reg, quote_next;

    logic is_lead, is_trail, is_letter, is_digit, is_blank, is_quote;
    logic act_keep, act_close, act_begin, act_err;

    record_t                   cand [NUM_CAND];
    logic [NUM_CAND-1:0]       cand_en;
    record_t [MAX_RECS-1:0]    recs;
    logic [1:0]                n_recs;
    record_t                   beg_rec;
    logic                      beg_sym;

    // Input register handshake
    assign go       = in_vld_reg && !q_full;
    assign in_stall = in_vld_reg && !go;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_vld_next = 1'b1;
        else if (go)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    // Hold the payload of the item under work
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_byte;
            eol_reg  <= line_end;
        end
    end

    // Classify the byte
    always_comb
    begin
        if (kanji_enc == ENC_EUC)
        begin
            is_lead  = (byte_reg >= EUC_LO) && (byte_reg <= EUC_HI);
            is_trail = (byte_reg >= EUC_LO) && (byte_reg <= EUC_HI);
        end
        else
        begin
            is_lead  = ((byte_reg >= SJIS_LEAD_A_LO) && (byte_reg <= SJIS_LEAD_A_HI)) ||
                       ((byte_reg >= SJIS_LEAD_B_LO) && (byte_reg <= SJIS_LEAD_B_HI));
            is_trail = ((byte_reg >= SJIS_TRAIL_A_LO) && (byte_reg <= SJIS_TRAIL_A_HI)) ||
                       ((byte_reg >= SJIS_TRAIL_B_LO) && (byte_reg <= SJIS_TRAIL_B_HI));
        end
        is_letter = ((byte_reg >= 8'h41) && (byte_reg <= 8'h5A)) ||
                    ((byte_reg >= 8'h61) && (byte_reg <= 8'h7A));
        is_digit  = (byte_reg >= 8'h30) && (byte_reg <= 8'h39);
        is_blank  = (byte_reg == CHR_NUL) || (byte_reg == CHR_SPACE) ||
                    (byte_reg == CHR_TAB);
        is_quote  = (byte_reg == CHR_SQUOTE) || (byte_reg == CHR_DQUOTE);
    end

    // Start of a new token from this byte
    always_comb
    begin
        beg_sym          = 1'b0;
        beg_rec.kind     = KIND_BYTE;
        beg_rec.data     = byte_reg;
        beg_rec.start    = 1'b1;
        beg_rec.cls      = CLS_SYMBOL;
        beg_mode         = MODE_IDLE;
        if (is_blank)
            beg_mode = MODE_IDLE;
        else if (is_lead)
        begin
            beg_rec.cls = CLS_KANJI;
            beg_mode    = MODE_KTRAIL;
        end
        else if (is_letter)
        begin
            beg_rec.cls = CLS_WORD;
            beg_mode    = MODE_WORD;
        end
        else if (is_digit)
        begin
            beg_rec.cls = CLS_NUMBER;
            beg_mode    = MODE_NUMBER;
        end
        else if (is_quote)
        begin
            beg_rec.cls = CLS_STRING;
            beg_mode    = MODE_STRING;
        end
        else
            beg_sym = 1'b1;
    end

    // Decide what this byte does to the open token
    always_comb
    begin
        act_keep  = 1'b0;
        act_close = 1'b0;
        act_begin = 1'b0;
        act_err   = 1'b0;
        mode_step = MODE_IDLE;
        unique case (mode_reg)
            MODE_KTRAIL:
            begin
                if (is_trail)
                begin
                    act_keep  = 1'b1;
                    mode_step = MODE_KOPEN;
                end
                else
                    act_err = 1'b1;
            end
            MODE_KOPEN:
            begin
                if (is_lead)
                begin
                    act_keep  = 1'b1;
                    mode_step = MODE_KTRAIL;
                end
                else
                begin
                    act_close = 1'b1;
                    act_begin = 1'b1;
                    mode_step = beg_mode;
                end
            end
            MODE_WORD:
            begin
                if (is_letter || is_digit)
                begin
                    act_keep  = 1'b1;
                    mode_step = MODE_WORD;
                end
                else
                begin
                    act_close = 1'b1;
                    act_begin = 1'b1;
                    mode_step = beg_mode;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit || (byte_reg == CHR_DOT) || (byte_reg == CHR_LOWER_E) ||
                    (byte_reg == CHR_UPPER_E))
                begin
                    act_keep  = 1'b1;
                    mode_step = MODE_NUMBER;
                end
                else
                begin
                    act_close = 1'b1;
                    act_begin = 1'b1;
                    mode_step = beg_mode;
                end
            end
            MODE_STRING:
            begin
                if ((byte_reg == CHR_NUL) || (byte_reg == quote_reg))
                    act_close = 1'b1;
                else if (byte_reg == CHR_BACKSLASH)
                begin
                    act_keep  = 1'b1;
                    mode_step = MODE_ESCAPE;
                end
                else
                begin
                    // drop a bare newline, keep anything else
                    act_keep  = (byte_reg != CHR_NEWLINE);
                    mode_step = MODE_STRING;
                end
            end
            MODE_ESCAPE:
            begin
                if (byte_reg == CHR_NUL)
                    act_close = 1'b1;
                else
                begin
                    act_keep  = 1'b1;
                    mode_step = MODE_STRING;
                end
            end
            default:
            begin
                act_begin = 1'b1;
                mode_step = beg_mode;
            end
        endcase
    end

    // Next scanner state: end of line always leaves the scanner idle
    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        if (go)
        begin
            mode_next = eol_reg ? MODE_IDLE : mode_step;
            if (act_begin && is_quote)
                quote_next = byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            quote_reg <= CHR_NUL;
        end
        else
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
        end
    end

    // Candidate records in emission order
    always_comb
    begin
        cand[0] = '{kind: KIND_ERROR, data: 8'h00, cls: CLS_KANJI, start: 1'b0};
        cand[1] = '{kind: KIND_BYTE, data: byte_reg, cls: mode_class(mode_reg),
                    start: 1'b0};
        cand[2] = '{kind: KIND_END, data: 8'h00, cls: mode_class(mode_reg), start: 1'b0};
        cand[3] = beg_rec;
        cand[4] = '{kind: KIND_END, data: 8'h00, cls: CLS_SYMBOL, start: 1'b0};
        if (mode_step == MODE_KTRAIL)
            cand[5] = '{kind: KIND_ERROR, data: 8'h00, cls: CLS_KANJI, start: 1'b0};
        else
            cand[5] = '{kind: KIND_END, data: 8'h00, cls: mode_class(mode_step),
                        start: 1'b0};

        cand_en[0] = act_err;
        cand_en[1] = act_keep;
        cand_en[2] = act_close;
        cand_en[3] = act_begin && !is_blank;
        cand_en[4] = act_begin && beg_sym;
        cand_en[5] = eol_reg && (mode_step != MODE_IDLE);
    end

    // Pack the enabled candidates into the bundle
    always_comb
    begin
        recs   = '0;
        n_recs = 2'd0;
        for (int i = 0; i < NUM_CAND; i++)
        begin
            if (cand_en[i] && (n_recs != 2'(MAX_RECS)))
            begin
                recs[n_recs] = cand[i];
                n_recs       = n_recs + 2'd1;
            end
        end
    end

    assign push.vld        = go && (n_recs != 2'd0);
    assign push.bundle.rec = recs;
    assign push.bundle.cnt = n_recs;

endmodule

// ===== hw/rtl/blt_queue.sv =====
module blt_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  blt_pkg::push_t   push,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output blt_pkg::record_t out_rec,
    output logic             out_last
);
    import blt_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bundle_t            slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         idx_reg, idx_next;
    bundle_t            head;
    logic               take;
    logic               pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];
    assign out_rec   = head.rec[idx_reg];
    assign out_last  = (idx_reg == (head.cnt - 2'd1));
    assign take      = out_valid && !out_stall;
    assign pop       = take && out_last;

    // Store a bundle
    always_ff @(posedge clk)
    begin
        if (push.vld)
            slots[wr_ptr_reg] <= push.bundle;
    end

    // Advance pointers, fill count and record index
    always_comb
    begin
        wr_ptr_next = push.vld ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.vld) - CNT_W'(pop);
        if (take)
            idx_next = out_last ? 2'd0 : idx_reg + 2'd1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

// ===== hw/rtl/basic_line_tokenizer.sv =====
// Line tokenizer: takes text bytes and gives tagged token records.
// Input channel: in_valid/in_stall with in_byte and line_end (last byte of
// a line, which closes any open token). Output channel: out_valid/out_stall
// with record_kind, out_byte, token_class, token_start and last, which
// marks the final record caused by one input item.
// Configuration: kanji_encoding is written through cfg_valid/cfg_ready
// while the block is idle, a rule for the user that the block does not
// enforce; cfg_ready is always high. An item enters the input register, is
// scanned combinationally and its one to three records land as one bundle in
// a queue of QUEUE_DEPTH bundles (a power of two, 2 or more); an item with no
// record pushes none. The first record of an item is offered once its bundle
// is stored. Throughput: one item per cycle while each item gives at most one
// record and the receiver does not stall; otherwise set by the single-record
// output port; an item that closes a token and starts a symbol gives three.
// Reset clears the scanner to idle, empties the queue and sets Shift-JIS.
// A stalled receiver holds the current record; the queue then fills and
// in_stall rises once the scanned item finds no free bundle slot.
module basic_line_tokenizer #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] record_kind,
    output logic [7:0] out_byte,
    output logic [2:0] token_class,
    output logic       token_start,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       kanji_encoding
);
    import blt_pkg::*;

    logic    enc_reg;
    push_t   push;
    logic    q_full;
    record_t rec;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enc_reg <= ENC_SJIS;
        else if (cfg_valid && cfg_ready)
            enc_reg <= kanji_encoding;
    end

    blt_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .line_end  (line_end),
        .kanji_enc (enc_reg),
        .q_full    (q_full),
        .push      (push)
    );

    blt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rec   (rec),
        .out_last  (last)
    );

    // Unpack the record onto the ports
    assign record_kind = rec.kind;
    assign out_byte    = rec.data;
    assign token_class = rec.cls;
    assign token_start = rec.start;

    // Never push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push.vld |-> !q_full)
        else $error("bundle pushed into full queue");

    // A pushed bundle always carries at least one record
    assert property (@(posedge clk) disable iff (!rst_n)
        push.vld |-> (push.bundle.cnt != 2'd0))
        else $error("empty bundle pushed");

    // Only token byte records open a token
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_start) |-> (record_kind == KIND_BYTE))
        else $error("start flag on a non-byte record");

endmodule
